[sv/wgm_pkg.sv]
package wgm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int CHAR_W      = 8;
   localparam int KIND_W      = 2;
   localparam int RSP_W       = 8;

   localparam logic [CHAR_W-1:0] STAR_BYTE = 8'd42;
   localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'd63;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_END    = 2'd3
   } wgm_kind_type;

   typedef struct packed {
      logic rearm;
      logic step;
   } wgm_ctrl_type;

endpackage

[sv/wgm_cell.sv]
module wgm_cell
   import wgm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  wgm_ctrl_type      ctrl,
   input  logic              load,
   input  logic              head,
   input  logic              valid,
   input  logic [CHAR_W-1:0] char_value,
   input  logic              close_in,
   input  logic              step_in,
   output logic              close_out,
   output logic              step_out,
   output logic              closed
);

   logic              active_ff;
   logic              active_in;
   logic [CHAR_W-1:0] byte_ff;
   logic              star_ff;
   logic              any_ff;
   logic              live;

   assign closed    = active_ff | close_in;
   assign live      = valid & closed;
   assign close_out = live & star_ff;
   assign step_out  = live & ~star_ff & (any_ff | (byte_ff == char_value));

   always_comb begin
      if (ctrl.rearm) begin
         active_in = head;
      end else if (ctrl.step) begin
         active_in = close_out | step_in;
      end else begin
         active_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= head;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= char_value;
         star_ff <= (char_value == STAR_BYTE);
         any_ff  <= (char_value == ANY_BYTE);
      end
   end

endmodule

[sv/wildcard_glob_match.sv]
// Glob matcher over a byte stream: '*' matches any run of bytes, '?' any one byte. Each
// req beat carries a kind in tuser (clear, append pattern byte, text byte, end of text)
// and a byte in tdata; only end of text yields a rsp beat with matched and
// pattern_overflow. The pattern sits in a row of 32 cells, one per pattern position,
// each holding its byte and its reachable bit; a text byte updates every cell at once
// while the star closure ripples left to right through the row. Every kind is handled as
// its beat is accepted, so one beat is accepted per clock; rsp_tdata is registered and
// req_tready is high while that register is empty or taken in the same cycle, so input of
// any kind stalls only while a result waits with rsp_tready low.
// Patterns longer than 32 bytes set the overflow flag until the next clear.
module wildcard_glob_match
   import wgm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CHAR_W-1:0] req_tdata,   // [7:0] char_value
   input  logic [KIND_W-1:0] req_tuser,   // [1:0] kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

   logic             accept;
   wgm_kind_type     kind;
   wgm_ctrl_type     ctrl;
   logic             append;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             top_ff, top_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [PATTERN_MAX:0]   close_chain;
   logic [PATTERN_MAX:0]   step_chain;
   logic [PATTERN_MAX:0]   closed_vec;
   logic                   hit;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign kind       = wgm_kind_type'(req_tuser);

   always_comb begin
      ctrl.rearm = 1'b0;
      ctrl.step  = 1'b0;
      append     = 1'b0;
      if (accept) begin
         unique case (kind)
            KIND_CLEAR:  ctrl.rearm = 1'b1;
            KIND_APPEND: append     = 1'b1;
            KIND_TEXT:   ctrl.step  = 1'b1;
            KIND_END:    ctrl.rearm = 1'b1;
            default:     ctrl.rearm = 1'b0;
         endcase
      end
   end

   assign close_chain[0] = 1'b0;
   assign step_chain[0]  = 1'b0;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      wgm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load       (append && (len_ff == LEN_W'(g))),
         .head       (1'(g == 0)),
         .valid      (LEN_W'(g) < len_ff),
         .char_value (req_tdata),
         .close_in   (close_chain[g]),
         .step_in    (step_chain[g]),
         .close_out  (close_chain[g+1]),
         .step_out   (step_chain[g+1]),
         .closed     (closed_vec[g])
      );
   end

   assign closed_vec[PATTERN_MAX] = top_ff | close_chain[PATTERN_MAX];
   assign hit = closed_vec[len_ff];

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (accept && kind == KIND_CLEAR) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (append) begin
         if (len_ff < LEN_W'(PATTERN_MAX)) begin
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (ctrl.rearm) begin
         top_in = 1'b0;
      end else if (ctrl.step) begin
         top_in = step_chain[PATTERN_MAX];
      end else begin
         top_in = top_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept && kind == KIND_END) begin
         rsp_valid_in = 1'b1;
         matched_in   = hit & ~ovf_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         top_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-2){1'b0}}, rsp_ovf_ff, matched_ff};

endmodule
